[src/jse_pkg.sv]
// jse_pkg: types, constants and helper functions for the json string escaper
// used by jse_front, jse_queue, jse_back and json_string_escaper_core
package jse_pkg;

  localparam int MAX_BYTES    = 6;
  localparam int LEN_W        = 3;
  localparam int IDX_W        = 3;
  localparam int QUEUE_DEPTH  = 2;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 8;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_UNIT  = 2'd1,
    FUNC_END   = 2'd2,
    FUNC_ERROR = 2'd3
  } func_t;

  localparam logic [CFG_INDEX_W-1:0] REG_HEX_QUOTE     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEEP_SLASH    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HEX_TAG       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_EXTRA_ESCAPES = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_HEX_AMP       = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_HEX_APOS      = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_RAW_UNICODE   = 3'd6;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_L      = 8'h6C;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;

  localparam logic [7:0] CU_BS     = 8'h08;
  localparam logic [7:0] CU_TAB    = 8'h09;
  localparam logic [7:0] CU_LF     = 8'h0A;
  localparam logic [7:0] CU_FF     = 8'h0C;
  localparam logic [7:0] CU_CR     = 8'h0D;
  localparam logic [7:0] CU_PCT    = 8'h25;
  localparam logic [7:0] CU_AMP    = 8'h26;
  localparam logic [7:0] CU_APOS   = 8'h27;
  localparam logic [7:0] CU_LT     = 8'h3C;
  localparam logic [7:0] CU_GT     = 8'h3E;
  localparam logic [7:0] CU_AT     = 8'h40;

  localparam logic [15:0] SPACE_UNIT   = 16'h0020;
  localparam logic [15:0] ASCII_MAX    = 16'h007F;
  localparam logic [15:0] UTF8_2_LIMIT = 16'h0800;

  typedef struct packed {
    logic hex_quote;
    logic keep_slash;
    logic hex_tag;
    logic extra_escapes;
    logic hex_amp;
    logic hex_apos;
    logic raw_unicode;
  } jse_cfg_t;

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [LEN_W-1:0]          len;
    logic                      discard;
  } jse_desc_t;

  function automatic logic [7:0] hex_lower(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) r = CH_ZERO + {4'h0, n};
    else           r = 8'h57 + {4'h0, n};
    return r;
  endfunction

  function automatic logic [7:0] hex_upper(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) r = CH_ZERO + {4'h0, n};
    else           r = 8'h37 + {4'h0, n};
    return r;
  endfunction

endpackage

[src/json_string_escaper_core.sv]
// json_string_escaper_core: top level of the json string escaper
// depends on jse_pkg, jse_front, jse_queue, jse_back
//
//   channel  | direction | tdata / index     | tuser / data       | tlast
//   s_axis   | in        | code_unit[15:0]   | func[1:0]          | -
//   m_axis   | out       | out_byte[7:0]     | discard_prior      | last
//   cfg      | in        | cfg_index[2:0]    | cfg_data[7:0] bit0 | -
//
// one output byte per cycle, set by the back serializer and its output
// register, while m_axis_tready is high; an item produces 1 to 6 bytes
// first byte passes the front register, queue, back register and output register
// rst is synchronous and clears config, queue and all valid flags
// input and output stall independently through the front stage, the queue
// and the output register; cfg_ready is always high
module json_string_escaper_core
  import jse_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [15:0]            s_axis_tdata,   // code_unit
  input  logic [1:0]             s_axis_tuser,   // func
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [7:0]             m_axis_tdata,   // out_byte
  output logic                   m_axis_tlast,
  output logic                   m_axis_tuser,   // discard_prior
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic      push_valid;
  logic      push_ready;
  jse_desc_t push_desc;
  logic      pop_valid;
  logic      pop_ready;
  jse_desc_t pop_desc;

  assign cfg_ready = 1'b1;

  jse_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_desc     (push_desc)
  );

  jse_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_desc   (pop_desc)
  );

  jse_back u_back (
    .clk           (clk),
    .rst           (rst),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_desc      (pop_desc),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

[src/jse_front.sv]
// jse_front: accepts input transactions, holds the config registers and
// turns each item into a byte descriptor; depends on jse_pkg
module jse_front
  import jse_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [1:0]             s_axis_tuser,
  input  logic [15:0]            s_axis_tdata,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   push_valid,
  input  logic                   push_ready,
  output jse_desc_t              push_desc
);

  jse_cfg_t  cfg;
  jse_desc_t desc_next;
  jse_desc_t fr_desc;
  logic      fr_valid;
  func_t     func;
  logic [15:0] u;
  logic      general;

  assign func          = func_t'(s_axis_tuser);
  assign u             = s_axis_tdata;
  assign s_axis_tready = !fr_valid || push_ready;
  assign push_valid    = fr_valid;
  assign push_desc     = fr_desc;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HEX_QUOTE:     cfg.hex_quote     <= cfg_data[0];
        REG_KEEP_SLASH:    cfg.keep_slash    <= cfg_data[0];
        REG_HEX_TAG:       cfg.hex_tag       <= cfg_data[0];
        REG_EXTRA_ESCAPES: cfg.extra_escapes <= cfg_data[0];
        REG_HEX_AMP:       cfg.hex_amp       <= cfg_data[0];
        REG_HEX_APOS:      cfg.hex_apos      <= cfg_data[0];
        REG_RAW_UNICODE:   cfg.raw_unicode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    desc_next         = '0;
    desc_next.bytes   = '0;
    desc_next.len     = LEN_W'(1);
    desc_next.discard = 1'b0;
    general           = 1'b0;
    unique case (func)
      FUNC_START, FUNC_END: begin
        desc_next.bytes[0] = CH_QUOTE;
      end
      FUNC_ERROR: begin
        desc_next.bytes[0] = CH_N;
        desc_next.bytes[1] = CH_U;
        desc_next.bytes[2] = CH_L;
        desc_next.bytes[3] = CH_L;
        desc_next.len      = LEN_W'(4);
        desc_next.discard  = 1'b1;
      end
      FUNC_UNIT: begin
        // a backslash-u escape with upper-case hex is prefilled, arms below pick the length and replace bytes
        desc_next.bytes[0] = CH_BSLASH;
        desc_next.bytes[1] = CH_U;
        desc_next.bytes[2] = CH_ZERO;
        desc_next.bytes[3] = CH_ZERO;
        desc_next.bytes[4] = hex_upper(u[7:4]);
        desc_next.bytes[5] = hex_upper(u[3:0]);
        if (u[15:8] != 8'h00) begin
          general = 1'b1;
        end else begin
          unique case (u[7:0])
            CH_QUOTE: begin
              if (cfg.hex_quote) desc_next.len = LEN_W'(6);
              else begin
                desc_next.bytes[1] = CH_QUOTE;
                desc_next.len      = LEN_W'(2);
              end
            end
            CH_BSLASH: begin
              desc_next.bytes[1] = CH_BSLASH;
              desc_next.len      = LEN_W'(2);
            end
            CH_SLASH: begin
              if (cfg.keep_slash) desc_next.bytes[0] = CH_SLASH;
              else begin
                desc_next.bytes[1] = CH_SLASH;
                desc_next.len      = LEN_W'(2);
              end
            end
            CU_BS: begin
              desc_next.bytes[1] = CH_B;
              desc_next.len      = LEN_W'(2);
            end
            CU_FF: begin
              desc_next.bytes[1] = CH_F;
              desc_next.len      = LEN_W'(2);
            end
            CU_LF: begin
              desc_next.bytes[1] = CH_N;
              desc_next.len      = LEN_W'(2);
            end
            CU_CR: begin
              desc_next.bytes[1] = CH_R;
              desc_next.len      = LEN_W'(2);
            end
            CU_TAB: begin
              desc_next.bytes[1] = CH_T;
              desc_next.len      = LEN_W'(2);
            end
            CU_LT: begin
              if (cfg.hex_tag || cfg.extra_escapes) desc_next.len = LEN_W'(6);
              else desc_next.bytes[0] = u[7:0];
            end
            CU_GT: begin
              if (cfg.hex_tag) desc_next.len = LEN_W'(6);
              else desc_next.bytes[0] = u[7:0];
            end
            CU_AMP: begin
              if (cfg.hex_amp) desc_next.len = LEN_W'(6);
              else desc_next.bytes[0] = u[7:0];
            end
            CU_APOS: begin
              if (cfg.hex_apos) desc_next.len = LEN_W'(6);
              else desc_next.bytes[0] = u[7:0];
            end
            CU_AT, CU_PCT: begin
              if (cfg.extra_escapes) desc_next.len = LEN_W'(6);
              else desc_next.bytes[0] = u[7:0];
            end
            default: general = 1'b1;
          endcase
        end
        if (general) begin
          if (u >= SPACE_UNIT && cfg.raw_unicode) begin
            if (u <= ASCII_MAX) begin
              desc_next.bytes[0] = u[7:0];
              desc_next.len      = LEN_W'(1);
            end else if (u < UTF8_2_LIMIT) begin
              desc_next.bytes[0] = {3'b110, u[10:6]};
              desc_next.bytes[1] = {2'b10, u[5:0]};
              desc_next.len      = LEN_W'(2);
            end else begin
              desc_next.bytes[0] = {4'b1110, u[15:12]};
              desc_next.bytes[1] = {2'b10, u[11:6]};
              desc_next.bytes[2] = {2'b10, u[5:0]};
              desc_next.len      = LEN_W'(3);
            end
          end else if (u >= SPACE_UNIT && u <= ASCII_MAX) begin
            desc_next.bytes[0] = u[7:0];
            desc_next.len      = LEN_W'(1);
          end else begin
            desc_next.bytes[2] = hex_lower(u[15:12]);
            desc_next.bytes[3] = hex_lower(u[11:8]);
            desc_next.bytes[4] = hex_lower(u[7:4]);
            desc_next.bytes[5] = hex_lower(u[3:0]);
            desc_next.len      = LEN_W'(6);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      fr_valid <= 1'b1;
    end else if (push_ready) begin
      fr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      fr_desc <= desc_next;
    end
  end

endmodule

[src/jse_queue.sv]
// jse_queue: short descriptor queue between front and back
// depends on jse_pkg
module jse_queue
  import jse_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  jse_desc_t push_desc,
  output logic      pop_valid,
  input  logic      pop_ready,
  output jse_desc_t pop_desc
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  jse_desc_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_desc   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_desc;
    end
  end

endmodule

[src/jse_back.sv]
// jse_back: serializes descriptors into one output byte per transaction
// depends on jse_pkg
module jse_back
  import jse_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  jse_desc_t pop_desc,
  output logic      m_axis_tvalid,
  input  logic      m_axis_tready,
  output logic [7:0] m_axis_tdata,
  output logic      m_axis_tlast,
  output logic      m_axis_tuser
);

  jse_desc_t        cur;
  logic             cur_valid;
  logic [IDX_W-1:0] idx;
  logic             out_adv;
  logic             emit;
  logic             at_end;
  logic             done;
  logic             pop;

  assign out_adv   = !m_axis_tvalid || m_axis_tready;
  assign emit      = cur_valid && out_adv;
  assign at_end    = idx == IDX_W'(cur.len - 1'b1);
  assign done      = emit && at_end;
  assign pop_ready = !cur_valid || done;
  assign pop       = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (done) begin
      cur_valid <= 1'b0;
    end else if (emit) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_adv) begin
      m_axis_tvalid <= cur_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_axis_tdata <= cur.bytes[idx];
      m_axis_tlast <= at_end;
      m_axis_tuser <= cur.discard && (idx == '0);
    end
  end

  a_discard_on_n: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == CH_N)
    else $error("discard flag on a byte other than the first of null");

  a_discard_not_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> !m_axis_tlast)
    else $error("discard flag on the final byte of an item");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (idx < IDX_W'(cur.len)) && (cur.len != '0))
    else $error("byte index beyond descriptor length");

  a_load_starts_at_zero: assert property (@(posedge clk) disable iff (rst)
    pop |=> cur_valid && idx == '0)
    else $error("loaded descriptor does not start at its first byte");

endmodule
